/* rtl/core/assert_macros.svh */
// Assertion macros for the stroke expansion; only the vertex sequencer uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define TLQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlq: assertion failed");

// A cause in one cycle and its required effect in the next.
`define TLQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlq: assertion failed");

`endif

/* rtl/core/tlq_pkg.sv */
// Types, widths and arithmetic step functions of the thick line vertex generator.
package tlq_pkg;

  localparam int COORD_W   = 16;
  localparam int HW_W      = 14;
  localparam logic [HW_W-1:0] HW_RESET = 14'd16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int PROD_W    = MAG_W + HW_W;
  localparam int L2_W      = 2 * MAG_W + 1;
  localparam int NORM_BITS = 14;
  localparam int SQ_SHIFT  = 2 * NORM_BITS;
  localparam int ROOT_W    = 31;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int SQ_STAGES = (ROOT_W + 1) / 2;
  localparam int DIV_Q_W   = 15;
  localparam int DIV_STAGES = (DIV_Q_W + 1) / 2;
  localparam int NUM_W     = PROD_W + DIV_Q_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int DREM_W    = DEN_W + 1;
  localparam int VERT_W    = 3;
  localparam logic [VERT_W-1:0] VERT_LAST = 3'd7;
  localparam int VTX_SUM_W = COORD_W + 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      sx;
    logic                      sy;
    logic                      zero;
    logic [PROD_W-1:0]         px;
    logic [PROD_W-1:0]         py;
  } tlq_item_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_state_t;

  typedef struct packed {
    logic [DREM_W-1:0]  rem;
    logic [DIV_Q_W-1:0] quo;
  } div_state_t;

  // Bit pair j (from the top) of the radicand l2 * 2^28.
  function automatic logic [1:0] sq_pair(input logic [L2_W-1:0] l2, input int j);
    logic [RAD_W-1:0] n;
    logic [RAD_W-1:0] sh;
    n  = {{(RAD_W-L2_W-SQ_SHIFT){1'b0}}, l2, {SQ_SHIFT{1'b0}}};
    sh = n >> (RAD_W - 2 - 2 * j);
    return sh[1:0];
  endfunction

  function automatic sq_state_t sq_step(input sq_state_t s, input logic [1:0] pair);
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    sq_state_t           o;
    cur   = {s.rem[SQ_REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_state_t div_step(input div_state_t s, input logic nb,
                                          input logic [DEN_W-1:0] den);
    logic [DREM_W-1:0] cur;
    div_state_t        o;
    cur = {s.rem[DREM_W-2:0], nb};
    if (cur >= {1'b0, den}) begin
      o.rem = cur - {1'b0, den};
      o.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [VTX_SUM_W-1:0] v);
    logic [VTX_SUM_W-COORD_W:0] top;
    top = v[VTX_SUM_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      return v[COORD_W-1:0];
    end
    return v[VTX_SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

endpackage

/* rtl/core/tlq_front.sv */
// Front stages: segment differences, then squared length and scaled magnitudes.
module tlq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [tlq_pkg::COORD_W-1:0] ax,
  input  logic signed [tlq_pkg::COORD_W-1:0] ay,
  input  logic signed [tlq_pkg::COORD_W-1:0] bx,
  input  logic signed [tlq_pkg::COORD_W-1:0] by,
  input  logic [tlq_pkg::HW_W-1:0]          half_width,
  output logic                              out_valid,
  output tlq_pkg::tlq_item_t                out_item,
  output logic [tlq_pkg::L2_W-1:0]          out_l2
);

  logic                                    v1_r;
  logic signed [tlq_pkg::COORD_W-1:0]      ax1_r, ay1_r, bx1_r, by1_r;
  logic signed [tlq_pkg::DIFF_W-1:0]       dx_r, dy_r;
  logic signed [tlq_pkg::DIFF_W-1:0]       dx_nxt, dy_nxt;
  logic [tlq_pkg::DIFF_W-1:0]              mx_full, my_full;
  logic [tlq_pkg::MAG_W-1:0]               mx, my;
  logic [2*tlq_pkg::MAG_W-1:0]             sqx, sqy;
  logic                                    v2_r;
  tlq_pkg::tlq_item_t                      item_r, item_nxt;
  logic [tlq_pkg::L2_W-1:0]                l2_r, l2_nxt;

  assign dx_nxt = {bx[tlq_pkg::COORD_W-1], bx} - {ax[tlq_pkg::COORD_W-1], ax};
  assign dy_nxt = {by[tlq_pkg::COORD_W-1], by} - {ay[tlq_pkg::COORD_W-1], ay};

  always_comb begin
    mx_full = dx_r[tlq_pkg::DIFF_W-1] ? -dx_r : dx_r;
    my_full = dy_r[tlq_pkg::DIFF_W-1] ? -dy_r : dy_r;
    mx      = mx_full[tlq_pkg::MAG_W-1:0];
    my      = my_full[tlq_pkg::MAG_W-1:0];
    sqx     = mx * mx;
    sqy     = my * my;
    l2_nxt  = {1'b0, sqx} + {1'b0, sqy};
    item_nxt.ax   = ax1_r;
    item_nxt.ay   = ay1_r;
    item_nxt.bx   = bx1_r;
    item_nxt.by   = by1_r;
    item_nxt.sx   = dx_r[tlq_pkg::DIFF_W-1];
    item_nxt.sy   = dy_r[tlq_pkg::DIFF_W-1];
    item_nxt.zero = (dx_r == '0) && (dy_r == '0);
    item_nxt.px   = mx * half_width;
    item_nxt.py   = my * half_width;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    if (en) begin
      ax1_r  <= ax;
      ay1_r  <= ay;
      bx1_r  <= bx;
      by1_r  <= by;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      item_r <= item_nxt;
      l2_r   <= l2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_item  = item_r;
  assign out_l2    = l2_r;

endmodule

/* rtl/core/tlq_sqrt.sv */
// Pipelined integer square root of the squared length times 2^28, two root bits per stage (one in the last).
module tlq_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  tlq_pkg::tlq_item_t        in_item,
  input  logic [tlq_pkg::L2_W-1:0]  in_l2,
  output logic                      out_valid,
  output tlq_pkg::tlq_item_t        out_item,
  output logic [tlq_pkg::ROOT_W-1:0] out_root
);

  logic                     v_r    [tlq_pkg::SQ_STAGES];
  tlq_pkg::tlq_item_t       item_r [tlq_pkg::SQ_STAGES];
  logic [tlq_pkg::L2_W-1:0] l2_r   [tlq_pkg::SQ_STAGES];
  tlq_pkg::sq_state_t       st_r   [tlq_pkg::SQ_STAGES];
  logic                     v_src  [tlq_pkg::SQ_STAGES];
  tlq_pkg::tlq_item_t       i_src  [tlq_pkg::SQ_STAGES];
  logic [tlq_pkg::L2_W-1:0] l_src  [tlq_pkg::SQ_STAGES];
  tlq_pkg::sq_state_t       st_nxt [tlq_pkg::SQ_STAGES];

  always_comb begin
    tlq_pkg::sq_state_t s_in;
    tlq_pkg::sq_state_t s_mid;
    for (int s = 0; s < tlq_pkg::SQ_STAGES; s++) begin
      if (s == 0) begin
        v_src[s] = in_valid;
        i_src[s] = in_item;
        l_src[s] = in_l2;
        s_in     = '0;
      end else begin
        v_src[s] = v_r[s-1];
        i_src[s] = item_r[s-1];
        l_src[s] = l2_r[s-1];
        s_in     = st_r[s-1];
      end
      s_mid = tlq_pkg::sq_step(s_in, tlq_pkg::sq_pair(l_src[s], 2 * s));
      if (2 * s + 1 < tlq_pkg::ROOT_W) begin
        st_nxt[s] = tlq_pkg::sq_step(s_mid, tlq_pkg::sq_pair(l_src[s], 2 * s + 1));
      end else begin
        st_nxt[s] = s_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < tlq_pkg::SQ_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_src[s];
      end
      if (en) begin
        item_r[s] <= i_src[s];
        l2_r[s]   <= l_src[s];
        st_r[s]   <= st_nxt[s];
      end
    end
  end

  assign out_valid = v_r[tlq_pkg::SQ_STAGES-1];
  assign out_item  = item_r[tlq_pkg::SQ_STAGES-1];
  assign out_root  = st_r[tlq_pkg::SQ_STAGES-1].root;

endmodule

/* rtl/core/tlq_div.sv */
// Pipelined rounded divides of both scaled magnitudes by the length.
module tlq_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  tlq_pkg::tlq_item_t                in_item,
  input  logic [tlq_pkg::ROOT_W-1:0]        in_root,
  output logic                              out_valid,
  output tlq_pkg::tlq_item_t                out_item,
  output logic signed [tlq_pkg::COORD_W-1:0] out_ex,
  output logic signed [tlq_pkg::COORD_W-1:0] out_ey
);

  localparam int NS = tlq_pkg::DIV_STAGES;

  logic                      v0_r;
  tlq_pkg::tlq_item_t        item0_r;
  logic [tlq_pkg::DEN_W-1:0] den0_r;
  logic [tlq_pkg::NUM_W-1:0] nx0_r, ny0_r;
  logic [tlq_pkg::NUM_W-1:0] nx_nxt, ny_nxt;

  logic                      v_r    [NS];
  tlq_pkg::tlq_item_t        item_r [NS];
  logic [tlq_pkg::DEN_W-1:0] den_r  [NS];
  logic [tlq_pkg::NUM_W-1:0] nx_r   [NS];
  logic [tlq_pkg::NUM_W-1:0] ny_r   [NS];
  tlq_pkg::div_state_t       qx_r   [NS];
  tlq_pkg::div_state_t       qy_r   [NS];
  logic                      v_src  [NS];
  tlq_pkg::tlq_item_t        i_src  [NS];
  logic [tlq_pkg::DEN_W-1:0] d_src  [NS];
  logic [tlq_pkg::NUM_W-1:0] nx_src [NS];
  logic [tlq_pkg::NUM_W-1:0] ny_src [NS];
  tlq_pkg::div_state_t       qx_nxt [NS];
  tlq_pkg::div_state_t       qy_nxt [NS];

  logic [tlq_pkg::DIV_Q_W-1:0] qx_fin, qy_fin;

  // Numerator 2 * |d| * w * 2^14 + r over denominator 2 * r rounds half up.
  assign nx_nxt = {1'b0, in_item.px, {tlq_pkg::DIV_Q_W{1'b0}}}
                + {{(tlq_pkg::NUM_W-tlq_pkg::ROOT_W){1'b0}}, in_root};
  assign ny_nxt = {1'b0, in_item.py, {tlq_pkg::DIV_Q_W{1'b0}}}
                + {{(tlq_pkg::NUM_W-tlq_pkg::ROOT_W){1'b0}}, in_root};

  always_comb begin
    tlq_pkg::div_state_t sx_in, sy_in, sx_mid, sy_mid;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        v_src[s]  = v0_r;
        i_src[s]  = item0_r;
        d_src[s]  = den0_r;
        nx_src[s] = nx0_r;
        ny_src[s] = ny0_r;
        sx_in.rem = {2'b00, nx0_r[tlq_pkg::NUM_W-1:tlq_pkg::DIV_Q_W]};
        sx_in.quo = '0;
        sy_in.rem = {2'b00, ny0_r[tlq_pkg::NUM_W-1:tlq_pkg::DIV_Q_W]};
        sy_in.quo = '0;
      end else begin
        v_src[s]  = v_r[s-1];
        i_src[s]  = item_r[s-1];
        d_src[s]  = den_r[s-1];
        nx_src[s] = nx_r[s-1];
        ny_src[s] = ny_r[s-1];
        sx_in     = qx_r[s-1];
        sy_in     = qy_r[s-1];
      end
      sx_mid = tlq_pkg::div_step(sx_in, nx_src[s][tlq_pkg::DIV_Q_W-1-2*s], d_src[s]);
      sy_mid = tlq_pkg::div_step(sy_in, ny_src[s][tlq_pkg::DIV_Q_W-1-2*s], d_src[s]);
      if (2 * s + 1 < tlq_pkg::DIV_Q_W) begin
        qx_nxt[s] = tlq_pkg::div_step(sx_mid, nx_src[s][tlq_pkg::DIV_Q_W-2-2*s], d_src[s]);
        qy_nxt[s] = tlq_pkg::div_step(sy_mid, ny_src[s][tlq_pkg::DIV_Q_W-2-2*s], d_src[s]);
      end else begin
        qx_nxt[s] = sx_mid;
        qy_nxt[s] = sy_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
    if (en) begin
      item0_r <= in_item;
      den0_r  <= {in_root, 1'b0};
      nx0_r   <= nx_nxt;
      ny0_r   <= ny_nxt;
    end
    for (int s = 0; s < NS; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_src[s];
      end
      if (en) begin
        item_r[s] <= i_src[s];
        den_r[s]  <= d_src[s];
        nx_r[s]   <= nx_src[s];
        ny_r[s]   <= ny_src[s];
        qx_r[s]   <= qx_nxt[s];
        qy_r[s]   <= qy_nxt[s];
      end
    end
  end

  // A zero-length segment keeps a zero direction.
  always_comb begin
    qx_fin = item_r[NS-1].zero ? '0 : qx_r[NS-1].quo;
    qy_fin = item_r[NS-1].zero ? '0 : qy_r[NS-1].quo;
    out_ex = item_r[NS-1].sx ? -$signed({1'b0, qx_fin}) : $signed({1'b0, qx_fin});
    out_ey = item_r[NS-1].sy ? -$signed({1'b0, qy_fin}) : $signed({1'b0, qy_fin});
  end

  assign out_valid = v_r[NS-1];
  assign out_item  = item_r[NS-1];

endmodule

/* rtl/core/tlq_emit.sv */
// Vertex sequencer: holds one segment and sends its eight strip vertices.
`include "assert_macros.svh"

module tlq_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  tlq_pkg::tlq_item_t                 in_item,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_ex,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_ey,
  output logic                               load,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tlq_pkg::COORD_W-1:0] out_vertex_x,
  output logic signed [tlq_pkg::COORD_W-1:0] out_vertex_y,
  output logic [tlq_pkg::VERT_W-1:0]         out_vertex_number,
  output logic                               out_last_vertex
);

  localparam int SW = tlq_pkg::VTX_SUM_W;

  logic                               hold_v_r;
  logic [tlq_pkg::VERT_W-1:0]         count_r;
  logic signed [tlq_pkg::COORD_W-1:0] ax_r, ay_r, bx_r, by_r, ex_r, ey_r;
  logic                               out_valid_r;
  logic signed [tlq_pkg::COORD_W-1:0] out_x_r, out_y_r;
  logic [tlq_pkg::VERT_W-1:0]         out_num_r;
  logic                               out_last_r;

  logic                               out_free, emit, is_last;
  logic signed [SW-1:0]               bx_s, by_s, ex_s, ey_s, vx, vy;
  logic signed [tlq_pkg::COORD_W-1:0] vx_nxt, vy_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = hold_v_r && out_free;
  assign is_last  = (count_r == tlq_pkg::VERT_LAST);
  assign load     = in_valid && (!hold_v_r || (emit && is_last));

  // Vertices 0-3 sit at the start point, 4-7 at the end point; odd ones take +N,
  // the first pair steps back by e and the last pair steps forward by e.
  always_comb begin
    bx_s = count_r[2] ? SW'(bx_r) : SW'(ax_r);
    by_s = count_r[2] ? SW'(by_r) : SW'(ay_r);
    ex_s = SW'(ex_r);
    ey_s = SW'(ey_r);
    vx   = bx_s + (count_r[0] ? -ey_s : ey_s);
    vy   = by_s + (count_r[0] ? ex_s : -ex_s);
    if (count_r[2:1] == 2'b00) begin
      vx = vx - ex_s;
      vy = vy - ey_s;
    end else if (count_r[2:1] == 2'b11) begin
      vx = vx + ex_s;
      vy = vy + ey_s;
    end
    vx_nxt = tlq_pkg::sat_coord(vx);
    vy_nxt = tlq_pkg::sat_coord(vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        hold_v_r <= 1'b1;
        count_r  <= '0;
      end else if (emit) begin
        if (is_last) begin
          hold_v_r <= 1'b0;
        end
        count_r <= count_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      ax_r <= in_item.ax;
      ay_r <= in_item.ay;
      bx_r <= in_item.bx;
      by_r <= in_item.by;
      ex_r <= in_ex;
      ey_r <= in_ey;
    end
    if (emit) begin
      out_x_r    <= vx_nxt;
      out_y_r    <= vy_nxt;
      out_num_r  <= count_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_x      = out_x_r;
  assign out_vertex_y      = out_y_r;
  assign out_vertex_number = out_num_r;
  assign out_last_vertex   = out_last_r;

  `TLQ_ASSERT_NEXT(a_hold_until_last, emit && !is_last, hold_v_r)
  `TLQ_ASSERT_NEXT(a_load_restarts, load, hold_v_r && count_r == '0)
  `TLQ_ASSERT(a_last_tag, out_valid_r |-> (out_last_r == (out_num_r == tlq_pkg::VERT_LAST)))

endmodule

/* rtl/core/thick_line_quad_vertices.sv */
// Thick line stroke expansion: segment in, eight square-capped strip vertices out.
//
// Input channel (in_valid / in_stall): one word is a segment, start and end point
// in signed Q12.4. Output channel (out_valid / out_stall): one word is a vertex,
// with its strip position 0 to 7 and a last flag on position 7. The half width
// register is written through cfg_write_en / cfg_half_width; write it only while
// the block idles, as the block itself does not enforce this. The front end is a
// 27-stage pipeline (differences and squares, square root at two bits per stage,
// two dividers at two quotient bits per stage); the vertex sequencer sends one
// vertex per cycle while the receiver does not stall, while up to 27 more segments
// travel the pipeline behind the segment it holds.
// Reset clears all valid bits and sets the half width to 16 (one pixel).
// When the receiver stalls, the output word holds, the sequencer waits, and once
// the last pipeline stage is full the whole pipeline freezes and in_stall rises.
module thick_line_quad_vertices (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [tlq_pkg::COORD_W-1:0] in_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tlq_pkg::COORD_W-1:0] out_vertex_x,
  output logic signed [tlq_pkg::COORD_W-1:0] out_vertex_y,
  output logic [tlq_pkg::VERT_W-1:0]         out_vertex_number,
  output logic                               out_last_vertex,
  input  logic                               cfg_write_en,
  input  logic [tlq_pkg::HW_W-1:0]           cfg_half_width
);

  logic [tlq_pkg::HW_W-1:0]           half_width_r;
  logic                               en, load;
  logic                               f_valid, s_valid, d_valid;
  tlq_pkg::tlq_item_t                 f_item, s_item, d_item;
  logic [tlq_pkg::L2_W-1:0]           f_l2;
  logic [tlq_pkg::ROOT_W-1:0]         s_root;
  logic signed [tlq_pkg::COORD_W-1:0] d_ex, d_ey;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= tlq_pkg::HW_RESET;
    end else if (cfg_write_en) begin
      half_width_r <= cfg_half_width;
    end
  end

  // The pipeline moves unless its last stage holds a segment the sequencer cannot take.
  assign en       = !d_valid || load;
  assign in_stall = !en;

  tlq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .ax         (in_start_x),
    .ay         (in_start_y),
    .bx         (in_end_x),
    .by         (in_end_y),
    .half_width (half_width_r),
    .out_valid  (f_valid),
    .out_item   (f_item),
    .out_l2     (f_l2)
  );

  tlq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_l2     (f_l2),
    .out_valid (s_valid),
    .out_item  (s_item),
    .out_root  (s_root)
  );

  tlq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_item   (s_item),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_item  (d_item),
    .out_ex    (d_ex),
    .out_ey    (d_ey)
  );

  tlq_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (d_valid),
    .in_item           (d_item),
    .in_ex             (d_ex),
    .in_ey             (d_ey),
    .load              (load),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_vertex_number (out_vertex_number),
    .out_last_vertex   (out_last_vertex)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the thick line square-cap vertex generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
  } segment_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         num;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_vertex_x, out_vertex_y;
  logic [2:0] out_vertex_number;
  logic out_last_vertex;
  logic cfg_write_en = 1'b0;
  logic [tlq_pkg::HW_W-1:0] cfg_half_width = '0;

  segment_t segment_queue[$];
  vertex_t  vertex_queue[$];
  logic [tlq_pkg::HW_W-1:0] stroke_half_width;
  int  error_count = 0;
  bit  allow_gaps = 1'b1;
  bit  sender_hold = 1'b0;
  int  long_hold_cycles = 0;

  thick_line_quad_vertices i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_vertex_number(out_vertex_number), .out_last_vertex(out_last_vertex),
    .cfg_write_en(cfg_write_en), .cfg_half_width(cfg_half_width)
  );

  always #4 clk = ~clk;

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint scaled_component(longint c, longint unsigned w,
                                              longint unsigned r);
    longint unsigned mag, num, q;
    mag = (c < 0) ? -c : c;
    num = (mag * w) << 14;
    q = (2 * num + r) / (2 * r);
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic predict_vertices(segment_t s);
    longint ax, ay, bx, by, dx, dy, ex, ey, nx, ny;
    longint unsigned l2, r;
    longint vx[8], vy[8];
    vertex_t v;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    dx = bx - ax; dy = by - ay;
    l2 = dx * dx + dy * dy;
    ex = 0; ey = 0;
    if (l2 != 0) begin
      r = root_floor(l2 << 28);
      ex = scaled_component(dx, stroke_half_width, r);
      ey = scaled_component(dy, stroke_half_width, r);
    end
    nx = -ey; ny = ex;
    vx[0] = ax - nx - ex; vy[0] = ay - ny - ey;
    vx[1] = ax + nx - ex; vy[1] = ay + ny - ey;
    vx[2] = ax - nx;      vy[2] = ay - ny;
    vx[3] = ax + nx;      vy[3] = ay + ny;
    vx[4] = bx - nx;      vy[4] = by - ny;
    vx[5] = bx + nx;      vy[5] = by + ny;
    vx[6] = bx - nx + ex; vy[6] = by - ny + ey;
    vx[7] = bx + nx + ex; vy[7] = by + ny + ey;
    for (int k = 0; k < 8; k++) begin
      v.x = clamp16(vx[k]);
      v.y = clamp16(vy[k]);
      v.num = k[2:0];
      v.last = (k == 7);
      vertex_queue.push_back(v);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: gaps between words come in bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_vertices('{in_start_x, in_start_y, in_end_x, in_end_y});
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (segment_queue.size() > 0 && !sender_hold) begin
          in_valid   <= 1'b1;
          in_start_x <= segment_queue[0].ax;
          in_start_y <= segment_queue[0].ay;
          in_end_x   <= segment_queue[0].bx;
          in_end_y   <= segment_queue[0].by;
          void'(segment_queue.pop_front());
          if (allow_gaps && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall.
  int stall_left = 0;
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("unexpected word", out_vertex_number, -1);
        end else begin
          want = vertex_queue.pop_front();
          if (out_vertex_x !== want.x) report_mismatch("vertex_x", out_vertex_x, want.x);
          if (out_vertex_y !== want.y) report_mismatch("vertex_y", out_vertex_y, want.y);
          if (out_vertex_number !== want.num)
            report_mismatch("vertex_number", out_vertex_number, want.num);
          if (out_last_vertex !== want.last)
            report_mismatch("last_vertex", out_last_vertex, want.last);
        end
      end
      if (long_hold_cycles > 0) begin
        long_hold_cycles <= long_hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'(int'($urandom_range(0, 255)) - 128);
      2: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      default: return 16'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  task automatic add_segment(int ax, int ay, int bx, int by);
    segment_queue.push_back('{16'(ax), 16'(ay), 16'(bx), 16'(by)});
  endtask

  task automatic drain();
    while (segment_queue.size() > 0 || in_valid || vertex_queue.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_half_width(logic [tlq_pkg::HW_W-1:0] w);
    cfg_write_en   <= 1'b1;
    cfg_half_width <= w;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    stroke_half_width = w;
  endtask

  task automatic random_segments(int n);
    int ax, ay;
    for (int i = 0; i < n; i++) begin
      ax = random_coord();
      ay = random_coord();
      if ($urandom_range(0, 9) == 0) add_segment(ax, ay, ax, ay);
      else add_segment(ax, ay, random_coord(), random_coord());
    end
  endtask

  initial begin
    logic [tlq_pkg::HW_W-1:0] widths[4] = '{14'd0, 14'h3fff, 14'd40, 14'd1};
    stroke_half_width = tlq_pkg::HW_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: reset width, axes, diagonals, zero length and the range corners.
    add_segment(0, 0, 160, 0);
    add_segment(0, 0, 0, 160);
    add_segment(0, 0, -160, 0);
    add_segment(0, 0, 0, -160);
    add_segment(100, 100, 200, 200);
    add_segment(-50, 30, -50, 30);
    add_segment(-32768, -32768, 32767, 32767);
    add_segment(32767, -32768, -32768, 32767);
    add_segment(32767, 32767, 32767, 32767);
    add_segment(-32768, 0, -32768, 1);
    add_segment(0, 0, 1, 1);
    add_segment(32767, 0, 32767, -32768);
    drain();
    foreach (widths[i]) begin
      write_half_width(widths[i]);
      add_segment(0, 0, 160, 0);
      add_segment(-32768, -32768, 32767, 32767);
      add_segment(7, 7, 7, 7);
      add_segment(32000, -32000, 32767, -32768);
      random_segments(60);
      drain();
    end
    write_half_width(14'd16);
    // Long receiver hold while the sender keeps offering, to fill the pipeline.
    long_hold_cycles = 400;
    random_segments(40);
    drain();
    // Sender pauses until all results are in, then a final run with no idling.
    sender_hold = 1'b1;
    random_segments(10);
    while (vertex_queue.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    drain();
    allow_gaps = 1'b0;
    write_half_width(14'($urandom_range(0, 16383)));
    random_segments(40);
    drain();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
